@@ design/asn_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asn_pkg: shared types and constants of the analog sample normalizer
// Fixed field widths, configuration register indexes and the divider request.
// ----------------------------------------------------------------------------
package asn_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int STAMP_W    = 32;
    localparam int SENSOR_W   = 8;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_ADDR_W = 3;

    typedef logic [SAMPLE_W-1:0] sample_t;

    // configuration register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_ENABLE         = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SEND_ON_CHANGE = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_INVERT         = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_SEND_TIMESTAMP = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_RANGE_LOW      = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_RANGE_HIGH     = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_SENSOR_ID      = 3'd6;

    localparam sample_t RANGE_HIGH_RESET = 16'd4095;

    // request into the serial divider
    typedef struct packed {
        logic    start;
        sample_t dividend;   // clipped sample minus range low, never above divisor
        sample_t divisor;    // range span, nonzero
    } div_req_t;

endpackage : asn_pkg
`default_nettype wire

@@ design/analog_sample_normalizer_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// analog_sample_normalizer_top: clip, normalize and send-on-change filter
// Clips each ADC sample to the configured range, scales it to an unsigned
// Q1.FRACTION_BITS fraction with a serial divider, optionally inverts it and
// emits a result only when it moved more than the change threshold.
// ----------------------------------------------------------------------------
//  channel   ports                              direction  transaction
//  s_        s_valid/s_ready, sample, stamp     in         one ADC sample
//  m_        m_valid/m_ready, level, sensor,    out        zero or one per sample
//            stamp_out
//  cfg_      cfg_wr_en, cfg_addr, cfg_wr_data   in         one register write
//
//  One sample is in flight at a time. With a valid range s_ready returns
//  only after the prepare, divide and final steps, so no new sample is
//  taken before the last one is through; the one-bit-per-cycle quotient
//  loop in asn_div sets the length of the divide step. With an empty range
//  the divider is skipped and only the prepare and final steps remain.
//  Reset (aresetn low, synchronous) restores register defaults, clears
//  last sent level and drops any pending result.
//  A stalled result holds in the output register; the next sample is already
//  accepted and only waits in its final step if it also produces a result.
// ----------------------------------------------------------------------------
module analog_sample_normalizer_top #(
    parameter int FRACTION_BITS        = 16,
    parameter int CHANGE_THRESHOLD_LSB = 6
) (
    input  wire                                   aclk,
    input  wire                                   aresetn,
    // sample input
    input  wire                                   s_valid,
    output logic                                  s_ready,
    input  wire  [asn_pkg::SAMPLE_W-1:0]          s_sample,
    input  wire  [asn_pkg::STAMP_W-1:0]           s_stamp,
    // result output
    output logic                                  m_valid,
    input  wire                                   m_ready,
    output logic [FRACTION_BITS:0]                m_level,
    output logic [asn_pkg::SENSOR_W-1:0]          m_sensor,
    output logic [asn_pkg::STAMP_W-1:0]           m_stamp_out,
    // configuration writes
    input  wire                                   cfg_wr_en,
    input  wire  [asn_pkg::CFG_ADDR_W-1:0]        cfg_addr,
    input  wire  [asn_pkg::CFG_DATA_W-1:0]        cfg_wr_data
);

    localparam int LW = FRACTION_BITS + 1;
    localparam logic [LW-1:0] LEVEL_ONE = LW'(1) << FRACTION_BITS;
    localparam logic [LW-1:0] THRESHOLD = LW'(CHANGE_THRESHOLD_LSB);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_PREP = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    // configuration registers
    logic                              enable_reg;
    logic                              send_on_change_reg;
    logic                              invert_reg;
    logic                              send_timestamp_reg;
    asn_pkg::sample_t                  range_low_reg;
    asn_pkg::sample_t                  range_high_reg;
    logic [asn_pkg::SENSOR_W-1:0]      sensor_id_reg;

    // control and working registers
    logic [1:0]                        state_reg, state_next;
    asn_pkg::sample_t                  sample_reg;
    logic [asn_pkg::STAMP_W-1:0]       stamp_reg;
    logic                              empty_reg, empty_next;
    logic [LW-1:0]                     last_sent_reg, last_sent_next;

    // output register
    logic                              m_valid_reg, m_valid_next;
    logic [LW-1:0]                     m_level_reg;
    logic [asn_pkg::SENSOR_W-1:0]      m_sensor_reg;
    logic [asn_pkg::STAMP_W-1:0]       m_stamp_reg;

    asn_pkg::div_req_t                 div_req;
    logic                              div_done;
    logic [LW-1:0]                     quotient;

    asn_pkg::sample_t                  clipped;
    logic                              range_empty;
    logic [LW-1:0]                     raw_level;
    logic [LW-1:0]                     level;
    logic [LW-1:0]                     diff;
    logic                              send;
    logic                              out_free;
    logic                              load_out;

    // ------------------------------------------------------------------
    // configuration port: keep the low bits of each register's width
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg         <= 1'b0;
            send_on_change_reg <= 1'b0;
            invert_reg         <= 1'b0;
            send_timestamp_reg <= 1'b0;
            range_low_reg      <= '0;
            range_high_reg     <= asn_pkg::RANGE_HIGH_RESET;
            sensor_id_reg      <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                asn_pkg::REG_ENABLE:         enable_reg         <= cfg_wr_data[0];
                asn_pkg::REG_SEND_ON_CHANGE: send_on_change_reg <= cfg_wr_data[0];
                asn_pkg::REG_INVERT:         invert_reg         <= cfg_wr_data[0];
                asn_pkg::REG_SEND_TIMESTAMP: send_timestamp_reg <= cfg_wr_data[0];
                asn_pkg::REG_RANGE_LOW:      range_low_reg      <= cfg_wr_data;
                asn_pkg::REG_RANGE_HIGH:     range_high_reg     <= cfg_wr_data;
                asn_pkg::REG_SENSOR_ID: begin
                    sensor_id_reg <= cfg_wr_data[asn_pkg::SENSOR_W-1:0];
                end
                default: ;  // ignore writes beyond the register list
            endcase
        end
    end

    // ------------------------------------------------------------------
    // clip and span, evaluated in the prepare step
    // ------------------------------------------------------------------
    assign range_empty = range_high_reg <= range_low_reg;

    always_comb begin
        if (sample_reg < range_low_reg) begin
            clipped = range_low_reg;
        end else if (sample_reg > range_high_reg) begin
            clipped = range_high_reg;
        end else begin
            clipped = sample_reg;
        end
    end

    assign div_req.start    = (state_reg == ST_PREP) && !range_empty;
    assign div_req.dividend = clipped - range_low_reg;
    assign div_req.divisor  = range_high_reg - range_low_reg;

    asn_div #(
        .FRAC_BITS (FRACTION_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .done     (div_done),
        .quotient (quotient)
    );

    // ------------------------------------------------------------------
    // final step: invert, compare against the last sent level
    // ------------------------------------------------------------------
    assign raw_level = empty_reg ? '0 : quotient;
    assign level     = invert_reg ? LEVEL_ONE - raw_level : raw_level;
    assign diff      = (level >= last_sent_reg) ? level - last_sent_reg
                                                : last_sent_reg - level;
    assign send      = enable_reg && send_on_change_reg && (diff > THRESHOLD);
    assign out_free  = !m_valid_reg || m_ready;
    assign load_out  = (state_reg == ST_FIN) && send && out_free;

    always_comb begin
        state_next     = state_reg;
        empty_next     = empty_reg;
        last_sent_next = last_sent_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                // skip the divider when the range is empty or reversed
                empty_next = range_empty;
                state_next = range_empty ? ST_FIN : ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (!send) begin
                    state_next = ST_IDLE;
                end else if (out_free) begin
                    // load the result; while the output register is busy, hold here instead
                    last_sent_next = level;
                    m_valid_next   = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            last_sent_reg <= '0;
            m_valid_reg   <= 1'b0;
            empty_reg     <= 1'b0;
        end else begin
            state_reg     <= state_next;
            last_sent_reg <= last_sent_next;
            m_valid_reg   <= m_valid_next;
            empty_reg     <= empty_next;
        end
        if (s_valid && s_ready) begin
            sample_reg <= s_sample;
            stamp_reg  <= s_stamp;
        end
        if (load_out) begin
            m_level_reg  <= level;
            m_sensor_reg <= sensor_id_reg;
            m_stamp_reg  <= send_timestamp_reg ? stamp_reg : '0;
        end
    end

    assign s_ready     = (state_reg == ST_IDLE);
    assign m_valid     = m_valid_reg;
    assign m_level     = m_level_reg;
    assign m_sensor    = m_sensor_reg;
    assign m_stamp_out = m_stamp_reg;

endmodule : analog_sample_normalizer_top
`default_nettype wire

@@ design/asn_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asn_div: bit-serial restoring divider
// Computes (dividend << FRAC_BITS) / divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module asn_div #(
    parameter int FRAC_BITS = 16
) (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  asn_pkg::div_req_t      req,
    output logic                   done,
    output logic [FRAC_BITS:0]     quotient
);

    localparam int QW = FRAC_BITS + 1;
    localparam int RW = asn_pkg::SAMPLE_W + 1;
    localparam int CW = $clog2(FRAC_BITS + 2);

    logic [RW-1:0]               rem_reg, rem_next;
    logic [QW-1:0]               quo_reg, quo_next;
    asn_pkg::sample_t            divisor_reg;
    logic [CW-1:0]               cnt_reg, cnt_next;
    logic                        first_reg, first_next;
    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;

    logic [RW-1:0]               shifted;
    logic                        fits;

    // first step uses the remainder as loaded, later steps shift in a zero
    assign shifted = first_reg ? rem_reg : {rem_reg[RW-2:0], 1'b0};
    assign fits    = shifted >= {1'b0, divisor_reg};

    always_comb begin
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        first_next = first_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (req.start) begin
            rem_next   = {1'b0, req.dividend};
            quo_next   = '0;
            cnt_next   = CW'(QW);
            first_next = 1'b1;
            busy_next  = 1'b1;
        end else if (busy_reg) begin
            rem_next   = fits ? shifted - {1'b0, divisor_reg} : shifted;
            quo_next   = {quo_reg[QW-2:0], fits};
            cnt_next   = cnt_reg - CW'(1);
            first_next = 1'b0;
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        rem_reg   <= rem_next;
        quo_reg   <= quo_next;
        cnt_reg   <= cnt_next;
        first_reg <= first_next;
        if (req.start) begin
            divisor_reg <= req.divisor;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule : asn_div
`default_nettype wire

@@ design/asn_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// asn_checker: port-level checks of the analog sample normalizer
// Watches handshakes and result range; attached to the top level by bind.
// ----------------------------------------------------------------------------
module asn_checker #(
    parameter int FRACTION_BITS = 16
) (
    input wire                               aclk,
    input wire                               aresetn,
    input wire                               s_valid,
    input wire                               s_ready,
    input wire                               m_valid,
    input wire                               m_ready,
    input wire [FRACTION_BITS:0]             m_level,
    input wire [asn_pkg::SENSOR_W-1:0]       m_sensor,
    input wire [asn_pkg::STAMP_W-1:0]        m_stamp_out
);

    localparam int LW = FRACTION_BITS + 1;
    localparam logic [LW-1:0] LEVEL_ONE = LW'(1) << FRACTION_BITS;

    // a stalled result holds its payload
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_level)
                                && $stable(m_sensor) && $stable(m_stamp_out))
        else $error("result changed while stalled");

    // one sample in flight: input closes right after an acceptance
    a_one_in_flight: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input ready right after acceptance");

    // a new result is loaded only as the block returns to idle
    a_result_at_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> s_ready)
        else $error("result appeared while a sample is still in work");

    // level never exceeds one
    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_level <= LEVEL_ONE)
        else $error("level above one");

endmodule : asn_checker

bind analog_sample_normalizer_top asn_checker #(
    .FRACTION_BITS (FRACTION_BITS)
) u_asn_checker (.*);
`default_nettype wire
